[hw/rtl/smt_pkg.sv]
// Shared types and constants of the temperature softmax block.
// Depends on nothing.
package smt_pkg;
   typedef struct packed {
      logic signed [15:0] logit;
      logic               last_in;
   } req_type;

   typedef struct packed {
      logic [15:0] probability;
      logic [5:0]  channel_index;
      logic        last_out;
   } rsp_type;

   localparam logic [15:0] INV_TEMP_RESET = 16'd256;

   function automatic logic [16:0] exp_int(input logic [3:0] i);
      case (i)
         4'd0: exp_int = 17'd65536;  4'd1: exp_int = 17'd24109;
         4'd2: exp_int = 17'd8869;   4'd3: exp_int = 17'd3263;
         4'd4: exp_int = 17'd1200;   4'd5: exp_int = 17'd442;
         4'd6: exp_int = 17'd162;    4'd7: exp_int = 17'd60;
         4'd8: exp_int = 17'd22;     4'd9: exp_int = 17'd8;
         4'd10: exp_int = 17'd3;     4'd11: exp_int = 17'd1;
         default: exp_int = 17'd0;
      endcase
   endfunction

   function automatic logic [16:0] exp_hi(input logic [3:0] h);
      case (h)
         4'd0: exp_hi = 17'd65536;  4'd1: exp_hi = 17'd61565;
         4'd2: exp_hi = 17'd57835;  4'd3: exp_hi = 17'd54331;
         4'd4: exp_hi = 17'd51039;  4'd5: exp_hi = 17'd47947;
         4'd6: exp_hi = 17'd45042;  4'd7: exp_hi = 17'd42313;
         4'd8: exp_hi = 17'd39750;  4'd9: exp_hi = 17'd37341;
         4'd10: exp_hi = 17'd35079; 4'd11: exp_hi = 17'd32954;
         4'd12: exp_hi = 17'd30957; 4'd13: exp_hi = 17'd29081;
         4'd14: exp_hi = 17'd27319; default: exp_hi = 17'd25664;
      endcase
   endfunction

   function automatic logic [16:0] exp_lo(input logic [3:0] l);
      case (l)
         4'd0: exp_lo = 17'd65536;  4'd1: exp_lo = 17'd65280;
         4'd2: exp_lo = 17'd65026;  4'd3: exp_lo = 17'd64772;
         4'd4: exp_lo = 17'd64520;  4'd5: exp_lo = 17'd64268;
         4'd6: exp_lo = 17'd64018;  4'd7: exp_lo = 17'd63768;
         4'd8: exp_lo = 17'd63520;  4'd9: exp_lo = 17'd63272;
         4'd10: exp_lo = 17'd63025; 4'd11: exp_lo = 17'd62780;
         4'd12: exp_lo = 17'd62535; 4'd13: exp_lo = 17'd62291;
         4'd14: exp_lo = 17'd62048; default: exp_lo = 17'd61806;
      endcase
   endfunction
endpackage

[hw/rtl/smt_divider.sv]
// Restoring divider for (e*65536 + sum/2) / sum, one quotient bit a cycle.
// Depends on no other file; it uses none of the items of smt_pkg.
module smt_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] e_value,
   input  logic [22:0] sum_value,
   output logic        done,
   output logic [15:0] quotient
);
   localparam int NumBits = 34;

   logic [33:0] num_ff, num_in;
   logic [22:0] den_ff, den_in;
   logic [23:0] rem_ff, rem_in;
   logic [33:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [23:0] trial;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[22:0], num_ff[33]};
      if (start) begin
         num_in = {1'b0, e_value, 16'd0} + {12'd0, sum_value[22:1]};
         den_in = sum_value;
         rem_in = '0;
         quo_in = '0;
         cnt_in = 6'(NumBits);
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[32:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[32:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[32:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = (den_ff == '0) ? 16'd0 :
                     (quo_ff[33:16] != '0) ? 16'hFFFF : quo_ff[15:0];
endmodule

[hw/rtl/softmax_with_temperature.sv]
// Top level of the temperature softmax block: logit buffer, sequencer, exp unit, divider.
// Depends on smt_pkg and smt_divider.
//
// Logits arrive one per transfer on req_ (start while busy is low); each is scaled
// by the inverse temperature (0 treated as 256), written to a buffer of
// MAX_CHANNELS (64 by default) entries, and folded into a running maximum.
// Elements load back to back while busy is low. When the last flag arrives, or
// MAX_CHANNELS elements are held, busy rises and the buffer is swept twice: a
// sum pass (read, first table product, second product and accumulate) and an
// emit pass (read, two table products, 34 quotient bits in the bit-serial
// divider, result). Results leave on rsp_ for one cycle each, flagged by
// rsp_valid; the receiver cannot stall, so none is ever held back.
module softmax_with_temperature
   import smt_pkg::*;
#(
   parameter int MAX_CHANNELS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic [15:0] csr_data
);
   localparam int AddrBits = $clog2(MAX_CHANNELS);
   localparam int CntBits  = $clog2(MAX_CHANNELS + 1);

   localparam logic [2:0] ST_LOAD = 3'd0;
   localparam logic [2:0] ST_SRD  = 3'd1; // sum pass: read issued
   localparam logic [2:0] ST_SE1  = 3'd2; // first table product
   localparam logic [2:0] ST_SE2  = 3'd3; // second product, accumulate
   localparam logic [2:0] ST_ERD  = 3'd4; // emit pass: read issued
   localparam logic [2:0] ST_EE1  = 3'd5;
   localparam logic [2:0] ST_EE2  = 3'd6;
   localparam logic [2:0] ST_DIV  = 3'd7;

   logic signed [15:0] mem [MAX_CHANNELS];
   logic signed [15:0] rd_ff;

   logic [15:0]         inv_ff;
   logic [2:0]          st_ff, st_in;
   logic signed [15:0]  max_ff, max_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [CntBits-1:0]  idx_ff, idx_in;
   logic [22:0]         sum_ff, sum_in;
   logic [33:0]         t_ff, t_in;
   logic [16:0]         e_value;
   logic [3:0]          lo_ff, lo_in;
   logic                div_start;
   logic                div_done;
   logic [15:0]         div_q;

   logic accept;
   logic signed [16:0] k;
   logic signed [33:0] prod;
   logic signed [25:0] q;
   logic signed [15:0] scaled;
   logic [15:0] n;
   logic [AddrBits-1:0] rd_addr;
   logic rd_en;
   logic [33:0] t_round;
   logic [33:0] e_prod;

   assign accept    = start && !busy;
   assign busy      = (st_ff != ST_LOAD);
   assign csr_ready = 1'b1;

   // Scale, round to nearest Q8.8 (halves up, then floor), then saturate.
   assign k      = (inv_ff == '0) ? 17'sd256 : $signed({1'b0, inv_ff});
   assign prod   = req_data.logit * k + 34'sd128;
   assign q      = prod[33:8];
   assign scaled = (q > 26'sd32767) ? 16'sh7FFF :
                   (q < -26'sd32768) ? 16'sh8000 : q[15:0];

   assign n       = 16'(max_ff - rd_ff);
   assign t_round = t_ff + 34'd32768;
   assign e_prod  = 34'(t_round[32:16]) * 34'(exp_lo(lo_ff)) + 34'd32768;
   // exponential goes straight into the divider as it is loaded
   assign e_value = e_prod[32:16];

   always_comb begin
      st_in = st_ff; max_in = max_ff; cnt_in = cnt_ff; idx_in = idx_ff;
      sum_in = sum_ff; t_in = t_ff; lo_in = lo_ff;
      rd_en = 1'b0; rd_addr = idx_ff[AddrBits-1:0]; div_start = 1'b0;
      case (st_ff)
         ST_LOAD: begin
            if (accept) begin
               if (scaled > max_ff) max_in = scaled;
               cnt_in = cnt_ff + 1'b1;
               if (req_data.last_in || cnt_ff == CntBits'(MAX_CHANNELS - 1)) begin
                  st_in  = ST_SRD;
                  idx_in = '0;
                  sum_in = '0;
               end
            end
         end
         ST_SRD, ST_ERD: begin
            rd_en = 1'b1;
            st_in = (st_ff == ST_SRD) ? ST_SE1 : ST_EE1;
         end
         ST_SE1, ST_EE1: begin
            t_in  = (n[15:12] != 4'd0) ? 34'd0 :
                    34'(exp_int(n[11:8])) * 34'(exp_hi(n[7:4]));
            lo_in = n[3:0];
            st_in = (st_ff == ST_SE1) ? ST_SE2 : ST_EE2;
         end
         ST_SE2: begin
            sum_in = sum_ff + 23'(e_prod[32:16]);
            if (idx_ff + 1'b1 == cnt_ff) begin
               idx_in = '0;
               st_in  = ST_ERD;
            end else begin
               idx_in = idx_ff + 1'b1;
               st_in  = ST_SRD;
            end
         end
         ST_EE2: begin
            div_start = 1'b1;
            st_in = ST_DIV;
         end
         default: begin
            if (div_done) begin
               if (idx_ff + 1'b1 == cnt_ff) begin
                  st_in  = ST_LOAD;
                  max_in = 16'sh8000;
                  cnt_in = '0;
                  sum_in = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  st_in  = ST_ERD;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) mem[cnt_ff[AddrBits-1:0]] <= scaled;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in; lo_ff <= lo_in;
      if (reset) begin
         inv_ff <= INV_TEMP_RESET;
         st_ff  <= ST_LOAD;
         max_ff <= 16'sh8000;
         cnt_ff <= '0;
         idx_ff <= '0;
         sum_ff <= '0;
      end else begin
         if (csr_valid) inv_ff <= csr_data;
         st_ff  <= st_in;
         max_ff <= max_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         sum_ff <= sum_in;
      end
   end

   smt_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .e_value  (e_value),
      .sum_value(sum_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid              = div_done && st_ff == ST_DIV;
   assign rsp_data.probability   = div_q;
   assign rsp_data.channel_index = 6'(idx_ff);
   assign rsp_data.last_out      = (idx_ff + 1'b1 == cnt_ff);

   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside emit pass");
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_out |=> !busy) else $error("vector not closed");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntBits'(MAX_CHANNELS)) else $error("count overflow");
endmodule
